FILE: hw/rtl/dbc_pkg.sv
// Shared types, constants and defaults for the dark blob centroid block.
package dbc_pkg;

  localparam int PIX_W      = 8;
  localparam int CNT_W      = 21;
  localparam int SUM_W      = 30;
  localparam int CRD_W      = 10;
  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

  localparam logic [PIX_W-1:0]  DEF_BLACK_LEVEL  = 8'd10;
  localparam logic [CNT_W-1:0]  DEF_MIN_AREA     = 21'd3000;
  localparam logic [SIZE_W-1:0] DEF_FRAME_WIDTH  = 11'd640;
  localparam logic [SIZE_W-1:0] DEF_FRAME_HEIGHT = 11'd480;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLACK_LEVEL  = 2'd0,
    REG_MIN_AREA     = 2'd1,
    REG_FRAME_WIDTH  = 2'd2,
    REG_FRAME_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIV_COL,
    ST_DIV_ROW,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             first_of_frame;
  } pix_in_t;

  typedef struct packed {
    logic             target_found;
    logic [CRD_W-1:0] centre_col;
    logic [CRD_W-1:0] centre_row;
    logic [CNT_W-1:0] dark_count;
  } result_t;

  // Frame totals including the pixel being accepted.
  typedef struct packed {
    logic [CNT_W-1:0] dark_total;
    logic [SUM_W-1:0] col_sum;
    logic [SUM_W-1:0] row_sum;
  } frame_sum_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hw/rtl/dark_blob_centroid.sv
// Top level: config registers, frame-end sequencer and result register.
//
//  channel  signals                                 direction  payload
//  in       in_valid_i / in_ready_o / in_data_i     in         pix_in_t
//  out      out_valid_o / out_ready_i / out_data_o  out        result_t
//  cfg      cfg_valid_i / cfg_ready_o / cfg_index_i in         cfg_data_i
//
// One pixel item per cycle while accumulating. At the last pixel of a frame
// with a target, the shared divider runs col_sum and then row_sum, 30 steps
// each, and the result register is then loaded; no input is taken meanwhile.
// Without a target it is loaded straight away. Input also waits while the
// result register is still held by out_ready_i low. Reset loads the
// default configuration and clears counters and sums; cfg_ready_o is always high.
module dark_blob_centroid
  import dbc_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pix_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output result_t               out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [PIX_W-1:0]  black_level_q;
  logic [CNT_W-1:0]  min_area_q;
  logic [SIZE_W-1:0] frame_width_q;
  logic [SIZE_W-1:0] frame_height_q;

  seq_state_e state_q, state_d;

  logic             in_acc, frame_end, found, nonzero, frame_done;
  frame_sum_t       fsum;
  div_stat_t        div_stat;
  logic             div_start;
  logic [SUM_W-1:0] div_dividend, div_quo;
  logic [CNT_W-1:0] div_divisor;
  logic             load_out;

  logic             found_q, found_d;
  logic             nz_q, nz_d;
  logic [CNT_W-1:0] tot_q, tot_d;
  logic [SUM_W-1:0] rsum_q, rsum_d;
  logic [CRD_W-1:0] cx_q, cx_d;
  logic             out_valid_q, out_valid_d;
  result_t          out_data_q, out_data_d;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      black_level_q  <= DEF_BLACK_LEVEL;
      min_area_q     <= DEF_MIN_AREA;
      frame_width_q  <= DEF_FRAME_WIDTH;
      frame_height_q <= DEF_FRAME_HEIGHT;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_BLACK_LEVEL:  black_level_q  <= cfg_data_i[PIX_W-1:0];
        REG_MIN_AREA:     min_area_q     <= cfg_data_i[CNT_W-1:0];
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[SIZE_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  dbc_accum #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_en_i      (in_acc),
    .pix_i         (in_data_i),
    .black_level_i (black_level_q),
    .frame_width_i (frame_width_q),
    .frame_height_i(frame_height_q),
    .frame_end_o   (frame_end),
    .sum_o         (fsum)
  );

  dbc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .stat_o    (div_stat),
    .quotient_o(div_quo)
  );

  assign in_acc     = in_valid_i && in_ready_o;
  assign frame_done = in_acc && frame_end;
  assign found      = fsum.dark_total >= min_area_q;
  assign nonzero    = fsum.dark_total != '0;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ACCUM: begin
        if (frame_done) begin
          state_d = (found && nonzero) ? ST_DIV_COL : ST_DONE;
        end
      end
      ST_DIV_COL: begin
        if (div_stat.done) begin
          state_d = ST_DIV_ROW;
        end
      end
      ST_DIV_ROW: begin
        if (div_stat.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_ACCUM;
        end
      end
      default: state_d = ST_ACCUM;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o   = 1'b0;
    div_start    = 1'b0;
    load_out     = 1'b0;
    div_dividend = rsum_q;
    div_divisor  = tot_q;
    unique case (state_q)
      ST_ACCUM: begin
        in_ready_o   = 1'b1;
        div_start    = frame_done && found && nonzero;
        div_dividend = fsum.col_sum;
        div_divisor  = fsum.dark_total;
      end
      ST_DIV_COL: begin
        div_start = div_stat.done;
      end
      ST_DIV_ROW: ;
      ST_DONE: begin
        load_out = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  always_comb begin
    found_d = found_q;
    nz_d    = nz_q;
    tot_d   = tot_q;
    rsum_d  = rsum_q;
    cx_d    = cx_q;
    if (frame_done) begin
      found_d = found;
      nz_d    = found && nonzero;
      tot_d   = fsum.dark_total;
      rsum_d  = fsum.row_sum;
    end
    if (state_q == ST_DIV_COL && div_stat.done) begin
      cx_d = div_quo[CRD_W-1:0];
    end

    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d             = 1'b1;
      out_data_d.target_found = found_q;
      // quotient of the row pass is still held in the divider
      out_data_d.centre_col   = nz_q ? cx_q : '0;
      out_data_d.centre_row   = nz_q ? div_quo[CRD_W-1:0] : '0;
      out_data_d.dark_count   = tot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q    <= found_d;
    nz_q       <= nz_d;
    tot_q      <= tot_d;
    rsum_q     <= rsum_d;
    cx_q       <= cx_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: hw/rtl/dbc_accum.sv
// Raster position counters and saturating dark-pixel count and coordinate sums.
module dbc_accum
  import dbc_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_en_i,
  input  pix_in_t           pix_i,
  input  logic [PIX_W-1:0]  black_level_i,
  input  logic [SIZE_W-1:0] frame_width_i,
  input  logic [SIZE_W-1:0] frame_height_i,
  output logic              frame_end_o,
  output frame_sum_t        sum_o
);

  localparam int CW  = $clog2(MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CSW = ($clog2(MAX_COLS + 1) > SIZE_W) ? $clog2(MAX_COLS + 1) : SIZE_W;
  localparam int RSW = ($clog2(MAX_ROWS + 1) > SIZE_W) ? $clog2(MAX_ROWS + 1) : SIZE_W;

  logic [CW-1:0]    col_q, col_d, col_cur;
  logic [RW-1:0]    row_q, row_d, row_cur;
  logic [CNT_W-1:0] tot_q, tot_d, tot_cur, tot_nxt;
  logic [SUM_W-1:0] csum_q, csum_d, csum_cur, csum_nxt;
  logic [SUM_W-1:0] rsum_q, rsum_d, rsum_cur, rsum_nxt;
  logic [SUM_W:0]   csum_add, rsum_add;
  logic [CSW-1:0]   fw, w_use, last_col;
  logic [RSW-1:0]   fh, h_use, last_row;
  logic             dark, row_end, frame_end;

  always_comb begin
    // first_of_frame restarts before this pixel is counted
    col_cur  = pix_i.first_of_frame ? '0 : col_q;
    row_cur  = pix_i.first_of_frame ? '0 : row_q;
    tot_cur  = pix_i.first_of_frame ? '0 : tot_q;
    csum_cur = pix_i.first_of_frame ? '0 : csum_q;
    rsum_cur = pix_i.first_of_frame ? '0 : rsum_q;

    dark     = pix_i.pixel_value <= black_level_i;
    csum_add = {1'b0, csum_cur} + (SUM_W+1)'(col_cur);
    rsum_add = {1'b0, rsum_cur} + (SUM_W+1)'(row_cur);

    tot_nxt  = tot_cur;
    csum_nxt = csum_cur;
    rsum_nxt = rsum_cur;
    if (dark) begin
      tot_nxt  = (tot_cur == CNT_MAX) ? tot_cur : tot_cur + CNT_W'(1);
      csum_nxt = (csum_add > {1'b0, SUM_MAX}) ? SUM_MAX : csum_add[SUM_W-1:0];
      rsum_nxt = (rsum_add > {1'b0, SUM_MAX}) ? SUM_MAX : rsum_add[SUM_W-1:0];
    end

    // size 0 runs as 1, oversize runs as the maximum
    fw = CSW'(frame_width_i);
    fh = RSW'(frame_height_i);
    if (fw == '0) begin
      w_use = CSW'(1);
    end else if (fw > CSW'(MAX_COLS)) begin
      w_use = CSW'(MAX_COLS);
    end else begin
      w_use = fw;
    end
    if (fh == '0) begin
      h_use = RSW'(1);
    end else if (fh > RSW'(MAX_ROWS)) begin
      h_use = RSW'(MAX_ROWS);
    end else begin
      h_use = fh;
    end
    last_col  = w_use - CSW'(1);
    last_row  = h_use - RSW'(1);
    row_end   = CSW'(col_cur) >= last_col;
    frame_end = row_end && (RSW'(row_cur) >= last_row);

    col_d  = col_q;
    row_d  = row_q;
    tot_d  = tot_q;
    csum_d = csum_q;
    rsum_d = rsum_q;
    if (acc_en_i) begin
      if (frame_end) begin
        col_d  = '0;
        row_d  = '0;
        tot_d  = '0;
        csum_d = '0;
        rsum_d = '0;
      end else begin
        tot_d  = tot_nxt;
        csum_d = csum_nxt;
        rsum_d = rsum_nxt;
        if (row_end) begin
          col_d = '0;
          row_d = row_cur + RW'(1);
        end else begin
          col_d = col_cur + CW'(1);
          row_d = row_cur;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      tot_q  <= '0;
      csum_q <= '0;
      rsum_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      tot_q  <= tot_d;
      csum_q <= csum_d;
      rsum_q <= rsum_d;
    end
  end

  assign frame_end_o      = frame_end;
  assign sum_o.dark_total = tot_nxt;
  assign sum_o.col_sum    = csum_nxt;
  assign sum_o.row_sum    = rsum_nxt;

endmodule

FILE: hw/rtl/dbc_div.sv
// Restoring divider, one quotient bit per cycle, shared by both centroid axes.
module dbc_div
  import dbc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output div_stat_t        stat_o,
  output logic [SUM_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(SUM_W);

  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W:0]    shifted, diff;
  logic              fits;

  always_comb begin
    shifted = {rem_q, quo_q[SUM_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    fits    = shifted >= {1'b0, dvs_q};

    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // remainder stays below the divisor, so 21 bits hold it
      rem_d = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo_d = {quo_q[SUM_W-2:0], fits};
      cnt_d = cnt_q + STEP_W'(1);
      if (cnt_q == STEP_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule
